// File: rtl/z80_alu_with_flags_defines.svh
// assertion macros for the ALU pipeline
`ifndef Z80_ALU_WITH_FLAGS_DEFINES_SVH
`define Z80_ALU_WITH_FLAGS_DEFINES_SVH

// stalled output must hold its payload
`define Z80_ASSERT_HOLD(lbl, clk, rst, vld, rdy, dat) \
   lbl: assert property (@(posedge clk) disable iff (rst) \
      (vld && !rdy) |=> (vld && $stable(dat))) else $error("output changed while stalled");

// implication checked every edge
`define Z80_ASSERT_IMPLY(lbl, clk, rst, lhs, rhs) \
   lbl: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("implication failed");

`endif

// File: rtl/z80alu_pkg.sv
`default_nettype none
package z80alu_pkg;
   localparam logic [4:0] OP_ADD8 = 5'd0, OP_SUB8 = 5'd1, OP_INC8 = 5'd2, OP_DEC8 = 5'd3,
      OP_CP8 = 5'd4, OP_ADD16 = 5'd5, OP_SUB16 = 5'd6, OP_ADC16 = 5'd7, OP_SBC16 = 5'd8,
      OP_XOR = 5'd9, OP_OR = 5'd10, OP_AND = 5'd11, OP_DAA = 5'd12, OP_CPL = 5'd13,
      OP_SCF = 5'd14, OP_CCF = 5'd15, OP_BIT = 5'd16, OP_PAR = 5'd17, OP_IFF2 = 5'd18,
      OP_UNUSED = 5'd31;
   // first rotate code (RL) and first of the fast accumulator rotates (RLA)
   localparam logic [4:0] OP_RL = 5'd19, OP_RLA = 5'd27;
   localparam int FS = 7, FZ = 6, F5 = 5, FH = 4, F3 = 3, FPV = 2, FN = 1, FC = 0;

   typedef struct packed {
      logic [4:0]  op;
      logic [15:0] a;
      logic [15:0] b;
      logic [7:0]  fin;
      logic        cin;
      logic [7:0]  noise;
      logic        iff2;
   } req_type;

   // stage 2 view: raw adder outputs plus original request
   typedef struct packed {
      req_type     rq;
      logic [16:0] sum;    // a + b' + c, 17-bit
      logic [12:0] sum12;  // low 12 bit add for half carry
      logic [15:0] bx;     // effective second operand
      logic [15:0] rlog;   // logic/rotate/misc result
      logic [8:0]  daa_adj;
   } mid_type;

   typedef struct packed {
      logic [15:0] result;
      logic [7:0]  flags;
   } rsp_type;

   function automatic logic [7:0] sz53(input logic [7:0] v);
      sz53 = {v[7], (v == 8'h00), v[5], 1'b0, v[3], 3'b000};
   endfunction

   function automatic logic [7:0] sz53p(input logic [7:0] v);
      sz53p = sz53(v) | {5'b0, ~^v, 2'b00};
   endfunction
endpackage
`default_nettype wire

// File: rtl/z80_alu_with_flags.sv
`default_nettype none
// channel | dir | tdata fields (lsb first)
// req     | in  | op[4:0] a[20:5] b[36:21] fin[44:37] cin[45] noise[53:46] iff2[54], pad 56
// rsp     | out | result[15:0] flags_out[23:16]
// Three register stages (input, mid, output); one request per cycle while rsp is not stalled.
// Each stage advances when it is empty or the stage after it moves.
// Reset clears the valid bits only; payload registers are not reset.
// A stalled rsp holds its data; nothing is dropped or repeated.
`include "z80_alu_with_flags_defines.svh"
module z80_alu_with_flags (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [55:0] req_tdata,   // op, operand_a, operand_b, flags_in, cin, noise, iff2_in
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata    // result, flags_out
);
   z80alu_pkg::req_type rq_ff, rq_in;
   z80alu_pkg::mid_type md_ff, md_in;
   z80alu_pkg::rsp_type rs_ff, rs_in;
   logic v1_ff, v2_ff, v3_ff;
   logic mv3, mv2, mv1;

   assign mv3 = !v3_ff || rsp_tready;
   assign mv2 = !v2_ff || mv3;
   assign mv1 = !v1_ff || mv2;
   assign req_tready = mv1;

   assign rq_in = '{op: req_tdata[4:0], a: req_tdata[20:5], b: req_tdata[36:21],
                    fin: req_tdata[44:37], cin: req_tdata[45], noise: req_tdata[53:46],
                    iff2: req_tdata[54]};

   z80alu_front u_front (.rq(rq_ff), .md(md_in));
   z80alu_back  u_back  (.md(md_ff), .rs(rs_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (mv1) v1_ff <= req_tvalid;
         if (mv2) v2_ff <= v1_ff;
         if (mv3) v3_ff <= v2_ff;
      end
      if (mv1) rq_ff <= rq_in;
      if (mv2) md_ff <= md_in;
      if (mv3) rs_ff <= rs_in;
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata = {rs_ff.flags, rs_ff.result};

   `Z80_ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_tvalid, rsp_tready, rsp_tdata)
   `Z80_ASSERT_IMPLY(a_full_stall, clock, reset, v1_ff && v2_ff && v3_ff && !rsp_tready, !req_tready)
   `Z80_ASSERT_IMPLY(a_mid_moves, clock, reset, v2_ff && mv3, mv2)
endmodule
`default_nettype wire

// File: rtl/z80alu_front.sv
`default_nettype none
// stage 1: operand selection, adders and the simple result paths
module z80alu_front (
   input  wire z80alu_pkg::req_type rq,
   output z80alu_pkg::mid_type      md
);
   logic [15:0] a16, b16, bx;
   logic [7:0]  a, b, r8;
   logic        c, left, co, inb;
   logic [2:0]  kind;
   logic [4:0]  k;
   logic [8:0]  adj;

   always_comb begin
      a16 = rq.a;
      b16 = rq.b;
      a = rq.a[7:0];
      b = rq.b[7:0];
      c = 1'b0;
      bx = b16;
      case (rq.op)
         z80alu_pkg::OP_ADD8:  begin bx = {8'h00, b}; c = rq.cin; end
         z80alu_pkg::OP_SUB8:  begin bx = {8'h00, ~b}; c = ~rq.cin; end
         z80alu_pkg::OP_INC8:  begin bx = 16'h0001; end
         z80alu_pkg::OP_DEC8:  begin bx = 16'h00ff; end
         z80alu_pkg::OP_CP8:   begin bx = {8'h00, ~b}; c = 1'b1; end
         z80alu_pkg::OP_ADD16: begin bx = b16; end
         z80alu_pkg::OP_SUB16: begin bx = ~b16; c = 1'b1; end
         z80alu_pkg::OP_ADC16: begin bx = b16; c = rq.cin; end
         z80alu_pkg::OP_SBC16: begin bx = ~b16; c = ~rq.cin; end
         default:              begin bx = b16; end
      endcase
      if (rq.op == z80alu_pkg::OP_ADD8 || rq.op == z80alu_pkg::OP_SUB8 ||
          rq.op == z80alu_pkg::OP_INC8 || rq.op == z80alu_pkg::OP_DEC8 ||
          rq.op == z80alu_pkg::OP_CP8)
         a16 = {8'h00, a};
      md.rq = rq;
      md.bx = bx;
      md.sum = {1'b0, a16} + {1'b0, bx} + {16'h0000, c};
      md.sum12 = {1'b0, a16[11:0]} + {1'b0, bx[11:0]} + {12'h000, c};
      // DAA adjustment
      adj = 9'h000;
      if (a[3:0] > 4'h9 || rq.fin[z80alu_pkg::FH]) adj[3:0] = 4'h6;
      if (a > 8'h99 || rq.fin[z80alu_pkg::FC]) adj[7:4] = 4'h6;
      adj[8] = (a > 8'h99);
      md.daa_adj = adj;
      // rotates/shifts
      k = rq.op - z80alu_pkg::OP_RL;
      kind = k[3:1];
      left = rq.op[0];
      co = left ? a[7] : a[0];
      case (kind)
         3'd0:    inb = rq.cin;
         3'd2:    inb = left ? 1'b0 : a[7];
         3'd3:    inb = left;
         3'd4:    inb = rq.fin[z80alu_pkg::FC];
         default: inb = co;
      endcase
      r8 = left ? {a[6:0], inb} : {inb, a[7:1]};
      case (rq.op)
         z80alu_pkg::OP_XOR: md.rlog = {8'h00, a ^ b};
         z80alu_pkg::OP_OR:  md.rlog = {8'h00, a | b};
         z80alu_pkg::OP_AND: md.rlog = {8'h00, a & b};
         z80alu_pkg::OP_CPL: md.rlog = {8'h00, ~a};
         default:            md.rlog = {7'h00, co, r8};
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/z80alu_back.sv
`default_nettype none
// stage 2: result selection and flag assembly
module z80alu_back (
   input  wire z80alu_pkg::mid_type md,
   output z80alu_pkg::rsp_type      rs
);
   logic [7:0]  a, b, fin, r8, f, ab;
   logic [15:0] r16, a16, bx;
   logic        hc8;
   logic [7:0]  dr;

   always_comb begin
      a16 = md.rq.a;
      a = md.rq.a[7:0];
      b = md.rq.b[7:0];
      fin = md.rq.fin;
      bx = md.bx;
      r16 = md.sum[15:0];
      r8 = md.sum[7:0];
      hc8 = md.sum12[4] ^ a[4] ^ bx[4];
      ab = a & b;
      dr = fin[z80alu_pkg::FN] ? a - md.daa_adj[7:0] : a + md.daa_adj[7:0];
      rs.result = 16'h0000;
      f = fin;
      case (md.rq.op)
         z80alu_pkg::OP_ADD8, z80alu_pkg::OP_SUB8, z80alu_pkg::OP_CP8: begin
            f = z80alu_pkg::sz53(r8);
            f[z80alu_pkg::FC] = md.sum[8];
            f[z80alu_pkg::FH] = hc8;
            f[z80alu_pkg::FPV] = (a[7] ^ r8[7]) & (bx[7] ^ r8[7]);
            if (md.rq.op != z80alu_pkg::OP_ADD8) begin
               f[z80alu_pkg::FN] = 1'b1;
               f[z80alu_pkg::FC] = ~f[z80alu_pkg::FC];
               f[z80alu_pkg::FH] = ~f[z80alu_pkg::FH];
            end
            if (md.rq.op == z80alu_pkg::OP_CP8) begin
               f[z80alu_pkg::F5] = b[5];
               f[z80alu_pkg::F3] = b[3];
               rs.result = {8'h00, a};
            end else
               rs.result = {8'h00, r8};
         end
         z80alu_pkg::OP_INC8, z80alu_pkg::OP_DEC8: begin
            rs.result = {8'h00, r8};
            f = z80alu_pkg::sz53(r8);
            f[z80alu_pkg::FH] = r8[4] ^ a[4];
            f[z80alu_pkg::FC] = fin[z80alu_pkg::FC];
            if (md.rq.op == z80alu_pkg::OP_INC8)
               f[z80alu_pkg::FPV] = (r8 == 8'h80);
            else begin
               f[z80alu_pkg::FPV] = (r8 == 8'h7f);
               f[z80alu_pkg::FN] = 1'b1;
            end
         end
         z80alu_pkg::OP_ADD16, z80alu_pkg::OP_SUB16,
         z80alu_pkg::OP_ADC16, z80alu_pkg::OP_SBC16: begin
            rs.result = r16;
            f = {r16[15], (r16 == 16'h0000), r16[13], md.sum12[12], r16[11],
                 (a16[15] ^ r16[15]) & (bx[15] ^ r16[15]), 1'b0, md.sum[16]};
            if (md.rq.op == z80alu_pkg::OP_SUB16 || md.rq.op == z80alu_pkg::OP_SBC16) begin
               f[z80alu_pkg::FN] = 1'b1;
               f[z80alu_pkg::FC] = ~f[z80alu_pkg::FC];
               f[z80alu_pkg::FH] = ~f[z80alu_pkg::FH];
            end
            if (md.rq.op == z80alu_pkg::OP_ADD16 || md.rq.op == z80alu_pkg::OP_SUB16) begin
               f[z80alu_pkg::FS] = fin[z80alu_pkg::FS];
               f[z80alu_pkg::FZ] = fin[z80alu_pkg::FZ];
               f[z80alu_pkg::FPV] = fin[z80alu_pkg::FPV];
            end
         end
         z80alu_pkg::OP_XOR, z80alu_pkg::OP_OR, z80alu_pkg::OP_AND: begin
            rs.result = md.rlog;
            f = z80alu_pkg::sz53p(md.rlog[7:0]);
            f[z80alu_pkg::FH] = (md.rq.op == z80alu_pkg::OP_AND);
         end
         z80alu_pkg::OP_DAA: begin
            rs.result = {8'h00, dr};
            f = z80alu_pkg::sz53p(dr);
            f[z80alu_pkg::FH] = a[4] ^ dr[4];
            f[z80alu_pkg::FN] = fin[z80alu_pkg::FN];
            f[z80alu_pkg::FC] = md.daa_adj[8] | fin[z80alu_pkg::FC];
         end
         z80alu_pkg::OP_CPL: begin
            rs.result = md.rlog;
            f = {fin[7:6], md.rlog[5], 1'b1, md.rlog[3], fin[2], 1'b1, fin[0]};
         end
         z80alu_pkg::OP_SCF: begin
            rs.result = {8'h00, a};
            f = {fin[7:6], a[5], 1'b0, a[3], fin[2], 1'b0, 1'b1};
         end
         z80alu_pkg::OP_CCF: begin
            rs.result = {8'h00, a};
            f = {fin[7:6], a[5], fin[0], a[3], fin[2], 1'b0, ~fin[0]};
         end
         z80alu_pkg::OP_BIT:
            f = {ab[7], (ab == 8'h00), md.rq.noise[5], 1'b1, md.rq.noise[3],
                 (ab == 8'h00), 1'b0, fin[0]};
         z80alu_pkg::OP_PAR: f = z80alu_pkg::sz53p(a);
         z80alu_pkg::OP_IFF2: begin
            f = z80alu_pkg::sz53(a);
            f[z80alu_pkg::FPV] = md.rq.iff2;
            f[z80alu_pkg::FC] = fin[z80alu_pkg::FC];
         end
         z80alu_pkg::OP_UNUSED: f = fin;
         default: begin
            rs.result = {8'h00, md.rlog[7:0]};
            f = z80alu_pkg::sz53p(md.rlog[7:0]);
            f[z80alu_pkg::FC] = md.rlog[8];
            if (md.rq.op >= z80alu_pkg::OP_RLA) begin
               f[z80alu_pkg::FS] = fin[z80alu_pkg::FS];
               f[z80alu_pkg::FZ] = fin[z80alu_pkg::FZ];
               f[z80alu_pkg::FPV] = fin[z80alu_pkg::FPV];
            end
         end
      endcase
      rs.flags = f;
   end
endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
   localparam int N_ITEMS = 1900;
   localparam int CYCLE_LIMIT = 200000;

   class alu_scoreboard;
      logic [23:0] pending[$];
      int errors;
      int checked;

      function logic [7:0] szf(input logic [7:0] v);
         return {v[7], v == 8'h00, v[5], 1'b0, v[3], 3'b000};
      endfunction

      function logic [7:0] szpf(input logic [7:0] v);
         return szf(v) | {5'b0, ~^v, 2'b00};
      endfunction

      function logic [7:0] adder8(input logic [7:0] a, input logic [7:0] b,
                                  input logic c, output logic [7:0] f);
         logic [8:0] s;
         s = a + b + c;
         f = szf(s[7:0]);
         f[0] = s[8];
         f[4] = ({1'b0, a[3:0]} + b[3:0] + c) > 5'hf;
         f[2] = (a[7] ~^ b[7]) & (a[7] ^ s[7]);
         return s[7:0];
      endfunction

      function logic [15:0] adder16(input logic [15:0] a, input logic [15:0] b,
                                    input logic c, output logic [7:0] f);
         logic [16:0] s;
         s = a + b + c;
         f = 8'h00;
         f[5] = s[13];
         f[3] = s[11];
         f[0] = s[16];
         f[4] = ({1'b0, a[11:0]} + b[11:0] + c) > 13'hfff;
         f[7] = s[15];
         f[6] = s[15:0] == 16'h0;
         f[2] = (a[15] ~^ b[15]) & (a[15] ^ s[15]);
         return s[15:0];
      endfunction

      // returns {flags, result}
      function logic [23:0] alu_result(input z80alu_pkg::req_type q);
         logic [7:0] a, b, f, t, adj;
         logic [15:0] r;
         logic [3:0] kind;
         logic lft, co, ib;
         a = q.a[7:0];
         b = q.b[7:0];
         r = 16'h0;
         f = q.fin;
         case (q.op)
            z80alu_pkg::OP_ADD8: r = adder8(a, b, q.cin, f);
            z80alu_pkg::OP_SUB8: begin
               r = adder8(a, ~b, ~q.cin, f);
               f = (f | 8'h02) ^ 8'h11;
            end
            z80alu_pkg::OP_INC8: begin
               r = 8'(a + 1);
               f = szf(r[7:0]) | ((r[7:0] ^ a) & 8'h10) | (r == 16'h80 ? 8'h04 : 8'h0)
                   | (q.fin & 8'h01);
            end
            z80alu_pkg::OP_DEC8: begin
               r = 8'(a - 1);
               f = 8'h02 | szf(r[7:0]) | ((r[7:0] ^ a) & 8'h10)
                   | (r == 16'h7f ? 8'h04 : 8'h0) | (q.fin & 8'h01);
            end
            z80alu_pkg::OP_CP8: begin
               void'(adder8(a, ~b, 1'b1, f));
               f = (f | 8'h02) ^ 8'h11;
               f = (f & 8'hd7) | (b & 8'h28);
               r = a;
            end
            z80alu_pkg::OP_ADD16, z80alu_pkg::OP_SUB16: begin
               if (q.op == z80alu_pkg::OP_ADD16) r = adder16(q.a, q.b, 1'b0, t);
               else begin
                  r = adder16(q.a, ~q.b, 1'b1, t);
                  t = (t | 8'h02) ^ 8'h11;
               end
               f = (q.fin & 8'hc4) | (t & 8'h3b);
            end
            z80alu_pkg::OP_ADC16: r = adder16(q.a, q.b, q.cin, f);
            z80alu_pkg::OP_SBC16: begin
               r = adder16(q.a, ~q.b, ~q.cin, f);
               f = (f | 8'h02) ^ 8'h11;
            end
            z80alu_pkg::OP_XOR: begin r = a ^ b; f = szpf(r[7:0]); end
            z80alu_pkg::OP_OR:  begin r = a | b; f = szpf(r[7:0]); end
            z80alu_pkg::OP_AND: begin r = a & b; f = szpf(r[7:0]) | 8'h10; end
            z80alu_pkg::OP_DAA: begin
               adj = 8'h0;
               if (a[3:0] > 4'h9 || q.fin[z80alu_pkg::FH]) adj |= 8'h06;
               if (a > 8'h99 || q.fin[z80alu_pkg::FC]) adj |= 8'h60;
               r = q.fin[z80alu_pkg::FN] ? 8'(a - adj) : 8'(a + adj);
               f = szpf(r[7:0]) | (a > 8'h99 ? 8'h01 : 8'h0) | ((a ^ r[7:0]) & 8'h10)
                   | (q.fin & 8'h03);
            end
            z80alu_pkg::OP_CPL: begin
               r = a ^ 8'hff;
               f = (q.fin & 8'hc5) | 8'h12 | (r[7:0] & 8'h28);
            end
            z80alu_pkg::OP_SCF: begin r = a; f = (q.fin & 8'hc4) | (a & 8'h28) | 8'h01; end
            z80alu_pkg::OP_CCF: begin
               r = a;
               f = ((q.fin & 8'hc5) | (a & 8'h28) | (q.fin[z80alu_pkg::FC] ? 8'h10 : 8'h0))
                   ^ 8'h01;
            end
            z80alu_pkg::OP_BIT:
               f = (q.fin & 8'h01) | (q.noise & 8'h28) | ((a & b & 8'h80) ? 8'h80 : 8'h0)
                   | ((a & b) != 0 ? 8'h0 : 8'h44) | 8'h10;
            z80alu_pkg::OP_PAR: f = szpf(a);
            z80alu_pkg::OP_IFF2: f = szf(a) | (q.fin & 8'h01) | (q.iff2 ? 8'h04 : 8'h0);
            z80alu_pkg::OP_UNUSED: f = q.fin;
            default: begin
               kind = 4'((q.op - z80alu_pkg::OP_RL) >> 1);
               lft = q.op[0];
               co = lft ? a[7] : a[0];
               case (kind)
                  0: ib = q.cin;
                  2: ib = lft ? 1'b0 : a[7];
                  3: ib = lft;
                  4: ib = q.fin[z80alu_pkg::FC];
                  default: ib = co;
               endcase
               r = lft ? {8'h0, a[6:0], ib} : {8'h0, ib, a[7:1]};
               f = szpf(r[7:0]) | {7'b0, co};
               if (kind >= 4) f = (q.fin & 8'hc4) | (f & 8'h29);
            end
         endcase
         return {f, r};
      endfunction

      function void note_request(input z80alu_pkg::req_type q);
         pending.push_back(alu_result(q));
      endfunction

      function void check_response(input logic [23:0] d);
         logic [23:0] e;
         if (pending.size() == 0) begin
            $error("unexpected response %h", d);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (d[15:0] !== e[15:0]) begin
            $error("result: expected %h actual %h", e[15:0], d[15:0]);
            errors++;
         end
         if (d[23:16] !== e[23:16]) begin
            $error("flags_out: expected %h actual %h", e[23:16], d[23:16]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0;
   logic [55:0] req_tdata = '0;
   wire req_tready, rsp_tvalid;
   wire [23:0] rsp_tdata;
   alu_scoreboard sb = new();
   int cycles = 0;
   bit quiet = 0;  // no idling on either side
   int op_hits[32];

   z80_alu_with_flags dut (.*);

   always begin #5 clock = 1; #5 clock = 0; end

   function automatic z80alu_pkg::req_type unpack_req(input logic [55:0] d);
      z80alu_pkg::req_type q;
      q.op = d[4:0];
      q.a = d[20:5];
      q.b = d[36:21];
      q.fin = d[44:37];
      q.cin = d[45];
      q.noise = d[53:46];
      q.iff2 = d[54];
      return q;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(unpack_req(req_tdata));
            op_hits[req_tdata[4:0]]++;
         end
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         rsp_tready <= quiet || ($urandom_range(99) >= 26);
      end
   end

   task automatic send(input z80alu_pkg::req_type q);
      if (!quiet && $urandom_range(99) < 26) begin
         req_tvalid <= 0;
         do @(posedge clock); while ($urandom_range(99) < 26);
      end
      req_tvalid <= 1;
      req_tdata <= {1'b0, q.iff2, q.noise, q.cin, q.fin, q.b, q.a, q.op};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic z80alu_pkg::req_type rand_req(input logic [4:0] op);
      z80alu_pkg::req_type q;
      logic [63:0] rnd;
      rnd = {$urandom, $urandom};
      q = rnd[54:0];
      q.op = op;
      case ($urandom_range(7))
         0: q.a = 16'h0;
         1: q.a = 16'hffff;
         2: q.a = {$urandom_range(1) ? 8'h80 : 8'h7f, $urandom_range(1) ? 8'h80 : 8'h7f};
         default: ;
      endcase
      case ($urandom_range(7))
         0: q.b = 16'h0;
         1: q.b = 16'hffff;
         2: q.b = 16'h8000;
         3: q.b = q.a;
         default: ;
      endcase
      return q;
   endfunction

   initial begin
      z80alu_pkg::req_type q;
      repeat (11) @(posedge clock);
      reset <= 0;
      // directed: every op at extremes
      for (int op = 0; op < 32; op++) begin
         q = '0;
         q.op = 5'(op);
         q.a = (op % 2) ? 16'hffff : 16'h8000;
         q.b = (op % 3) ? 16'h7fff : 16'hffff;
         q.fin = (op % 2) ? 8'hff : 8'h00;
         q.cin = op[1];
         q.noise = 8'hff;
         q.iff2 = op[0];
         if (op == z80alu_pkg::OP_DAA) q.a = 16'h009a;
         send(q);
      end
      for (int i = 0; i < N_ITEMS; i++) begin
         quiet = (i >= 600 && i < 900);
         send(rand_req(5'($urandom_range(31))));
      end
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d responses over all 32 op codes, with %0d RL/RR-through-carry",
               sb.checked, op_hits[z80alu_pkg::OP_RL] + op_hits[z80alu_pkg::OP_RL + 5'd1]);
      if (sb.errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
